[hw/rtl/stack_machine_execute_assert.svh]
// assertion macros used by the stack machine rtl
`ifndef STACK_MACHINE_EXECUTE_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_ASSERT_SVH

// implication checked at every rising clock edge outside reset
`define SME_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/sme_pkg.sv]
// package for the stack machine: sizes, opcodes, status codes, divider request and response types
`timescale 1ns / 1ps
package sme_pkg;
    localparam int STACK_DEPTH = 256;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    localparam logic [4:0] OP_PUSH = 5'd0;
    localparam logic [4:0] OP_DUP = 5'd1;
    localparam logic [4:0] OP_DUPN = 5'd2;
    localparam logic [4:0] OP_POP = 5'd3;
    localparam logic [4:0] OP_POPN = 5'd4;
    localparam logic [4:0] OP_DEPTH = 5'd5;
    localparam logic [4:0] OP_ADD = 5'd6;
    localparam logic [4:0] OP_SUB = 5'd7;
    localparam logic [4:0] OP_MUL = 5'd8;
    localparam logic [4:0] OP_DIV = 5'd9;
    localparam logic [4:0] OP_MOD = 5'd10;
    localparam logic [4:0] OP_INC = 5'd11;
    localparam logic [4:0] OP_DEC = 5'd12;
    localparam logic [4:0] OP_ROT = 5'd13;
    localparam logic [4:0] OP_ROTN = 5'd14;
    localparam logic [4:0] OP_SWAP = 5'd15;
    localparam logic [4:0] OP_GT = 5'd16;
    localparam logic [4:0] OP_LT = 5'd17;
    localparam logic [4:0] OP_GTE = 5'd18;
    localparam logic [4:0] OP_LTE = 5'd19;
    localparam logic [4:0] OP_EQ = 5'd20;
    localparam logic [4:0] OP_NE = 5'd21;
    localparam logic [4:0] OP_OR = 5'd22;
    localparam logic [4:0] OP_AND = 5'd23;
    localparam logic [4:0] OP_XOR = 5'd24;
    localparam logic [4:0] OP_NOT = 5'd25;
    localparam logic [4:0] OP_JMP = 5'd26;
    localparam logic [4:0] OP_JIF = 5'd27;
    localparam logic [4:0] OP_JNIF = 5'd28;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_OVER = 3'd2;
    localparam logic [2:0] ST_DIVZ = 3'd3;
    localparam logic [2:0] ST_COUNT = 3'd4;

    typedef struct packed {
        logic start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [31:0] quo;
        logic [31:0] rem;
    } div_rsp_t;
endpackage

[hw/rtl/stack_machine_execute.sv]
// stack machine core: executes one instruction per transaction
//
//  channel | signals                              | dir | handshake
//  --------+--------------------------------------+-----+-----------------------
//  command | start, busy, operation, immediate    | in  | start high, busy low
//  result  | done, top_value, stack_depth,        | out | done strobe, one cycle
//          | jump_taken, jump_target, status      |     |
//
// push and depth write at once; pop, jmp, unknown ops and depth errors only re-read the top
// other ops first read the top three entries; div and mod then wait for 32 divider steps
// dupn and rotate-n then walk the stack one entry at a time before the top is re-read
// done strobes in the cycle after the last busy one, with busy low, so a new command can be accepted there
// reset clears the stack pointer; the stack ram itself is not cleared
// results cannot be stalled
`timescale 1ns / 1ps
`include "stack_machine_execute_assert.svh"
module stack_machine_execute
    import sme_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [4:0]         operation,
    input  logic signed [31:0] immediate,
    output logic               done,
    output logic signed [31:0] top_value,
    output logic [8:0]         stack_depth,
    output logic               jump_taken,
    output logic [15:0]        jump_target,
    output logic [2:0]         status
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD_A = 4'd1;  // read top
    localparam logic [3:0] S_RD_B = 4'd2;  // read second
    localparam logic [3:0] S_RD_C = 4'd3;  // read third
    localparam logic [3:0] S_EXEC = 4'd4;
    localparam logic [3:0] S_DIV = 4'd5;
    localparam logic [3:0] S_WR = 4'd6;
    localparam logic [3:0] S_MV_RD = 4'd7;
    localparam logic [3:0] S_MV_WR = 4'd8;
    localparam logic [3:0] S_MV_STEP = 4'd9;
    localparam logic [3:0] S_ROT_FIN = 4'd10;
    localparam logic [3:0] S_TOP = 4'd11;
    localparam logic [3:0] S_TOP_RD = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [4:0]        op_reg, op_next;
    logic [31:0]       imm_reg, imm_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [31:0]       a_reg, a_next;   // top
    logic [31:0]       b_reg, b_next;   // second
    logic [31:0]       c_reg, c_next;   // third or carried entry
    logic [31:0]       r_reg, r_next;
    logic [2:0]        st_reg, st_next;
    logic              jmp_reg, jmp_next;
    logic [SP_W-1:0]   idx_reg, idx_next;  // walk index
    logic [SP_W-1:0]   end_reg, end_next;
    logic              first_reg, first_next;  // first walk read fills the carry
    logic [2:0]        wcnt_reg, wcnt_next;  // pending writes for rot/swap
    logic              done_reg, done_next;
    logic [31:0]       top_reg, top_next;

    logic [31:0]       mem [STACK_DEPTH];
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;

    div_req_t          dreq;
    div_rsp_t          drsp;

    logic [31:0]       alu_sum;
    logic [31:0]       alu_out;
    logic              lt_s;
    logic [SP_W:0]     m_ext;
    logic [31:0]       mag;
    logic              cnt_big;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    sme_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // shared alu: add, subtract, multiply, compare, logic ops and inc/dec
    always_comb
    begin
        logic [32:0] diff;
        diff = {b_reg[31], b_reg} - {a_reg[31], a_reg};
        lt_s = diff[32];
        alu_sum = b_reg + a_reg;
        alu_out = '0;
        unique case (op_reg)
            OP_ADD: alu_out = alu_sum;
            OP_SUB: alu_out = diff[31:0];
            OP_MUL: alu_out = b_reg * a_reg;
            OP_GT: alu_out = {31'd0, !lt_s && (diff[31:0] != 32'd0)};
            OP_LT: alu_out = {31'd0, lt_s};
            OP_GTE: alu_out = {31'd0, !lt_s};
            OP_LTE: alu_out = {31'd0, lt_s || (diff[31:0] == 32'd0)};
            OP_EQ: alu_out = {31'd0, diff[31:0] == 32'd0};
            OP_NE: alu_out = {31'd0, diff[31:0] != 32'd0};
            OP_OR: alu_out = {31'd0, (b_reg != 32'd0) || (a_reg != 32'd0)};
            OP_AND: alu_out = {31'd0, (b_reg != 32'd0) && (a_reg != 32'd0)};
            OP_XOR: alu_out = {31'd0, (b_reg != 32'd0) != (a_reg != 32'd0)};
            OP_INC: alu_out = a_reg + 32'd1;
            OP_DEC: alu_out = a_reg - 32'd1;
            OP_NOT: alu_out = {31'd0, a_reg == 32'd0};
            default: alu_out = '0;
        endcase
    end

    assign m_ext = {1'b0, sp_reg} - {{SP_W{1'b0}}, 1'b1};
    assign mag = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    // count beyond what any sp range can hold
    assign cnt_big = (mag[31:SP_W] != '0);

    always_comb
    begin
        logic [SP_W:0] cnt_n;
        logic [SP_W:0] sum_n;
        logic [SP_W:0] k_n;
        state_next = state_reg;
        op_next = op_reg;
        imm_next = imm_reg;
        sp_next = sp_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        r_next = r_reg;
        st_next = st_reg;
        jmp_next = jmp_reg;
        idx_next = idx_reg;
        end_next = end_reg;
        first_next = first_reg;
        wcnt_next = wcnt_reg;
        done_next = 1'b0;
        top_next = top_reg;
        rd_addr = ADDR_W'(sp_reg - SP_W'(1));
        wr_en = 1'b0;
        wr_addr = ADDR_W'(sp_reg);
        wr_data = imm_reg;
        dreq = '0;
        cnt_n = {1'b0, mag[SP_W-1:0]};
        sum_n = m_ext + cnt_n;
        k_n = m_ext - cnt_n;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = operation;
                    imm_next = immediate;
                    st_next = ST_OK;
                    jmp_next = 1'b0;
                    state_next = S_RD_A;
                end
            end
            S_RD_A:
            begin
                // issue read of top; decide error cases on depth
                rd_addr = ADDR_W'(sp_reg - SP_W'(1));
                state_next = S_RD_B;
                priority case (op_reg)
                    OP_PUSH, OP_DEPTH:
                    begin
                        if (sp_reg >= SP_W'(STACK_DEPTH))
                        begin
                            st_next = ST_OVER;
                            state_next = S_TOP;
                        end
                        else
                        begin
                            state_next = S_WR;
                            r_next = (op_reg == OP_PUSH) ? imm_reg
                                                         : {{(32-SP_W){1'b0}}, sp_reg};
                        end
                    end
                    OP_JMP:
                    begin
                        jmp_next = 1'b1;
                        state_next = S_TOP;
                    end
                    OP_POP, OP_DUP, OP_DUPN, OP_POPN, OP_ROTN, OP_INC, OP_DEC,
                    OP_NOT, OP_JIF, OP_JNIF:
                    begin
                        if (sp_reg < SP_W'(1))
                        begin
                            st_next = ST_UNDER;
                            state_next = S_TOP;
                        end
                        else if (op_reg == OP_POP)
                        begin
                            sp_next = sp_reg - SP_W'(1);
                            state_next = S_TOP;
                        end
                        else if (op_reg == OP_DUP && sp_reg >= SP_W'(STACK_DEPTH))
                        begin
                            st_next = ST_OVER;
                            state_next = S_TOP;
                        end
                    end
                    OP_ROT:
                    begin
                        if (sp_reg < SP_W'(3))
                        begin
                            st_next = ST_UNDER;
                            state_next = S_TOP;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_LT, OP_GTE,
                    OP_LTE, OP_EQ, OP_NE, OP_OR, OP_AND, OP_XOR, OP_SWAP:
                    begin
                        if (sp_reg < SP_W'(2))
                        begin
                            st_next = ST_UNDER;
                            state_next = S_TOP;
                        end
                    end
                    default: state_next = S_TOP;
                endcase
            end
            S_RD_B:
            begin
                // top arrives now; read second
                a_next = rd_data;
                rd_addr = ADDR_W'(sp_reg - SP_W'(2));
                state_next = S_RD_C;
            end
            S_RD_C:
            begin
                b_next = rd_data;
                rd_addr = ADDR_W'(sp_reg - SP_W'(3));
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                c_next = rd_data;
                state_next = S_WR;
                priority case (op_reg)
                    OP_DUP:
                    begin
                        r_next = a_reg;
                    end
                    OP_INC, OP_DEC, OP_NOT:
                    begin
                        r_next = alu_out;
                        sp_next = sp_reg - SP_W'(1);
                    end
                    OP_JIF, OP_JNIF:
                    begin
                        sp_next = sp_reg - SP_W'(1);
                        jmp_next = ((a_reg != 32'd0) == (op_reg == OP_JIF));
                        state_next = S_TOP;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (a_reg == 32'd0)
                        begin
                            st_next = ST_DIVZ;
                            state_next = S_TOP;
                        end
                        else
                        begin
                            dreq.start = 1'b1;
                            dreq.num = b_reg;
                            dreq.den = a_reg;
                            state_next = S_DIV;
                        end
                    end
                    OP_SWAP:
                    begin
                        // write top to sp-2, then second to sp-1
                        sp_next = sp_reg - SP_W'(2);
                        r_next = a_reg;
                        c_next = b_reg;
                        wcnt_next = 3'd2;
                        state_next = S_MV_WR;
                    end
                    OP_ROT:
                    begin
                        sp_next = sp_reg - SP_W'(3);
                        r_next = b_reg;
                        wcnt_next = 3'd3;
                        state_next = S_MV_WR;
                    end
                    OP_POPN:
                    begin
                        if (a_reg[31])
                        begin
                            st_next = ST_COUNT;
                        end
                        else if (cnt_big || cnt_n > m_ext)
                        begin
                            st_next = ST_UNDER;
                        end
                        else
                        begin
                            sp_next = SP_W'(k_n);
                        end
                        state_next = S_TOP;
                    end
                    OP_DUPN:
                    begin
                        if (a_reg[31] || a_reg == 32'd0)
                        begin
                            st_next = ST_COUNT;
                            state_next = S_TOP;
                        end
                        else if (cnt_big || cnt_n > m_ext)
                        begin
                            st_next = ST_UNDER;
                            state_next = S_TOP;
                        end
                        else if (sum_n > (SP_W+1)'(STACK_DEPTH))
                        begin
                            st_next = ST_OVER;
                            state_next = S_TOP;
                        end
                        else
                        begin
                            // copy entries m-c+i to m+i
                            idx_next = SP_W'(k_n);
                            end_next = SP_W'(m_ext);
                            sp_next = SP_W'(sum_n);
                            state_next = S_MV_RD;
                        end
                    end
                    OP_ROTN:
                    begin
                        if (cnt_big || cnt_n > m_ext)
                        begin
                            st_next = ST_UNDER;
                            state_next = S_TOP;
                        end
                        else
                        begin
                            sp_next = SP_W'(m_ext);
                            first_next = 1'b1;
                            // positive walks k up to m-1, negative walks m-1 down to k
                            if (a_reg[31])
                            begin
                                idx_next = SP_W'(m_ext) - SP_W'(1);
                                end_next = SP_W'(k_n);
                            end
                            else
                            begin
                                idx_next = SP_W'(k_n);
                                end_next = SP_W'(m_ext) - SP_W'(1);
                            end
                            state_next = (cnt_n == '0) ? S_TOP : S_MV_RD;
                        end
                    end
                    default:
                    begin
                        r_next = alu_out;
                        sp_next = sp_reg - SP_W'(2);
                    end
                endcase
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    r_next = (op_reg == OP_MOD) ? drsp.rem : drsp.quo;
                    sp_next = sp_reg - SP_W'(2);
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                wr_en = 1'b1;
                wr_addr = ADDR_W'(sp_reg);
                wr_data = r_reg;
                sp_next = sp_reg + SP_W'(1);
                top_next = r_reg;
                state_next = S_DONE;
            end
            S_MV_WR:
            begin
                // sequential writes from sp upward for swap and rot
                wr_en = 1'b1;
                wr_addr = ADDR_W'(sp_reg);
                wr_data = r_reg;
                sp_next = sp_reg + SP_W'(1);
                top_next = r_reg;
                wcnt_next = wcnt_reg - 3'd1;
                if (op_reg == OP_ROT)
                begin
                    r_next = (wcnt_reg == 3'd3) ? a_reg : c_reg;
                end
                else
                begin
                    r_next = c_reg;
                end
                if (wcnt_reg == 3'd1)
                begin
                    state_next = S_DONE;
                end
            end
            S_MV_RD:
            begin
                rd_addr = ADDR_W'(idx_reg);
                state_next = S_MV_STEP;
            end
            S_MV_STEP:
            begin
                // read data of idx is here; perform one move step
                state_next = S_MV_RD;
                if (op_reg == OP_DUPN)
                begin
                    wr_en = 1'b1;
                    wr_addr = ADDR_W'(idx_reg + sp_reg - end_reg);
                    wr_data = rd_data;
                    idx_next = idx_reg + SP_W'(1);
                    if (idx_reg + SP_W'(1) == end_reg)
                    begin
                        state_next = S_TOP;
                    end
                end
                else
                begin
                    if (first_reg)
                    begin
                        c_next = rd_data;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        wr_addr = a_reg[31] ? ADDR_W'(idx_reg + SP_W'(1))
                                            : ADDR_W'(idx_reg - SP_W'(1));
                        wr_data = rd_data;
                    end
                    if (idx_reg == end_reg)
                    begin
                        state_next = S_ROT_FIN;
                    end
                    else if (a_reg[31])
                    begin
                        idx_next = idx_reg - SP_W'(1);
                    end
                    else
                    begin
                        idx_next = idx_reg + SP_W'(1);
                    end
                end
            end
            S_ROT_FIN:
            begin
                wr_en = 1'b1;
                wr_addr = ADDR_W'(end_reg);
                wr_data = c_reg;
                state_next = S_TOP;
            end
            S_TOP:
            begin
                rd_addr = ADDR_W'(sp_reg - SP_W'(1));
                state_next = S_TOP_RD;
            end
            S_TOP_RD:
            begin
                top_next = rd_data;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg <= '0;
            done_reg <= 1'b0;
            wcnt_reg <= '0;
            st_reg <= ST_OK;
            jmp_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
            done_reg <= done_next;
            wcnt_reg <= wcnt_next;
            st_reg <= st_next;
            jmp_reg <= jmp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        imm_reg <= imm_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        r_reg <= r_next;
        idx_reg <= idx_next;
        end_reg <= end_next;
        first_reg <= first_next;
        top_reg <= top_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign top_value = (sp_reg == '0) ? 32'sd0 : $signed(top_reg);
    assign stack_depth = 9'(sp_reg);
    assign jump_taken = jmp_reg;
    assign jump_target = jmp_reg ? imm_reg[15:0] : 16'd0;
    assign status = st_reg;

    `SME_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `SME_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    `SME_ASSERT_IMPL(a_sp_range, clk, rst_n, 1'b1, sp_reg <= SP_W'(STACK_DEPTH))
    `SME_ASSERT_IMPL(a_jump_ok, clk, rst_n, done && jump_taken, status == ST_OK)
endmodule

[hw/rtl/sme_divider.sv]
// radix-2 restoring signed divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sme_divider
    import sme_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        qneg_reg, qneg_next;
    logic        rneg_reg, rneg_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        done_next = 1'b0;
        shifted = {rem_reg, quo_reg[31]};
        trial = shifted - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next = req.num[31] ? (32'd0 - req.num) : req.num;
            den_next = req.den[31] ? (32'd0 - req.den) : req.den;
            rem_next = '0;
            cnt_next = 6'd32;
            busy_next = 1'b1;
            qneg_next = req.num[31] ^ req.den[31];
            rneg_next = req.num[31];
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo = qneg_reg ? (32'd0 - quo_reg) : quo_reg;
    assign rsp.rem = rneg_reg ? (32'd0 - rem_reg) : rem_reg;
endmodule

[test/stack_machine_execute_tb.sv]
// testbench for stack_machine_execute: directed and random instruction streams checked against a stack model
`timescale 1ns / 1ps
module stack_machine_execute_tb
    import sme_pkg::*;
();

    typedef struct {
        logic [4:0]  op;
        logic [31:0] imm;
    } instr_t;

    typedef struct {
        logic [31:0] top;
        logic [8:0]  depth;
        logic        jmp;
        logic [15:0] target;
        logic [2:0]  st;
    } outcome_t;

    logic               clk;
    logic               rst_n;
    logic               start = 1'b0;
    logic               busy;
    logic [4:0]         operation = OP_PUSH;
    logic signed [31:0] immediate = '0;
    logic               done;
    logic signed [31:0] top_value;
    logic [8:0]         stack_depth;
    logic               jump_taken;
    logic [15:0]        jump_target;
    logic [2:0]         status;

    instr_t      instr_q[$];
    outcome_t    outcome_q[$];
    logic [31:0] stk [0:STACK_DEPTH-1];
    int          sp_model = 0;
    int          errors = 0;
    int          gap = 0;
    int          n_driven = 0;
    int          n_accepted = 0;
    int          n_checked = 0;
    int          n_items;

    stack_machine_execute u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .immediate  (immediate),
        .done       (done),
        .top_value  (top_value),
        .stack_depth(stack_depth),
        .jump_taken (jump_taken),
        .jump_target(jump_target),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // executes one instruction on the model stack
    function automatic outcome_t execute_instr(input logic [4:0] op, input logic [31:0] imm);
        outcome_t    o;
        int          sp;
        logic [2:0]  st;
        logic        jmp;
        longint      c, m, mag, x, y;
        logic [31:0] r, xu, yu;
        sp = sp_model;
        st = ST_OK;
        jmp = 1'b0;
        r = '0;
        case (op)
            OP_PUSH:
                if (sp >= STACK_DEPTH) st = ST_OVER;
                else begin stk[sp] = imm; sp++; end
            OP_DUP:
                if (sp < 1) st = ST_UNDER;
                else if (sp >= STACK_DEPTH) st = ST_OVER;
                else begin stk[sp] = stk[sp-1]; sp++; end
            OP_DUPN, OP_POPN, OP_ROTN:
                if (sp < 1) st = ST_UNDER;
                else
                begin
                    c = longint'($signed(stk[sp-1]));
                    m = sp - 1;
                    if (op == OP_DUPN)
                    begin
                        if (c <= 0) st = ST_COUNT;
                        else if (c > m) st = ST_UNDER;
                        else if (m + c > STACK_DEPTH) st = ST_OVER;
                        else
                        begin
                            for (longint i = 0; i < c; i++) stk[m+i] = stk[m-c+i];
                            sp = int'(m + c);
                        end
                    end
                    else if (op == OP_POPN)
                    begin
                        if (c < 0) st = ST_COUNT;
                        else if (c > m) st = ST_UNDER;
                        else sp = int'(m - c);
                    end
                    else
                    begin
                        mag = (c < 0) ? -c : c;
                        if (mag > m) st = ST_UNDER;
                        else
                        begin
                            if (c > 0)
                            begin
                                r = stk[m-c];
                                for (longint i = m - c; i < m - 1; i++) stk[i] = stk[i+1];
                                stk[m-1] = r;
                            end
                            else if (c < 0)
                            begin
                                r = stk[m-1];
                                for (longint i = m - 1; i > m - mag; i--) stk[i] = stk[i-1];
                                stk[m-mag] = r;
                            end
                            sp = int'(m);
                        end
                    end
                end
            OP_POP:
                if (sp < 1) st = ST_UNDER;
                else sp--;
            OP_DEPTH:
                if (sp >= STACK_DEPTH) st = ST_OVER;
                else begin stk[sp] = sp; sp++; end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_LT, OP_GTE, OP_LTE,
            OP_EQ, OP_NE, OP_OR, OP_AND, OP_XOR:
                if (sp < 2) st = ST_UNDER;
                else
                begin
                    xu = stk[sp-2];
                    yu = stk[sp-1];
                    x = longint'($signed(xu));
                    y = longint'($signed(yu));
                    if ((op == OP_DIV || op == OP_MOD) && y == 0) st = ST_DIVZ;
                    else
                    begin
                        case (op)
                            OP_ADD: r = xu + yu;
                            OP_SUB: r = xu - yu;
                            OP_MUL: r = xu * yu;
                            OP_DIV: r = 32'(x / y);
                            OP_MOD: r = 32'(x % y);
                            OP_GT:  r = {31'b0, x > y};
                            OP_LT:  r = {31'b0, x < y};
                            OP_GTE: r = {31'b0, x >= y};
                            OP_LTE: r = {31'b0, x <= y};
                            OP_EQ:  r = {31'b0, x == y};
                            OP_NE:  r = {31'b0, x != y};
                            OP_OR:  r = {31'b0, (xu != 0) || (yu != 0)};
                            OP_AND: r = {31'b0, (xu != 0) && (yu != 0)};
                            default: r = {31'b0, (xu != 0) != (yu != 0)};
                        endcase
                        stk[sp-2] = r;
                        sp--;
                    end
                end
            OP_INC, OP_DEC, OP_NOT:
                if (sp < 1) st = ST_UNDER;
                else if (op == OP_INC) stk[sp-1] = stk[sp-1] + 32'd1;
                else if (op == OP_DEC) stk[sp-1] = stk[sp-1] - 32'd1;
                else stk[sp-1] = (stk[sp-1] == 0) ? 32'd1 : 32'd0;
            OP_ROT:
                if (sp < 3) st = ST_UNDER;
                else
                begin
                    r = stk[sp-3];
                    stk[sp-3] = stk[sp-2];
                    stk[sp-2] = stk[sp-1];
                    stk[sp-1] = r;
                end
            OP_SWAP:
                if (sp < 2) st = ST_UNDER;
                else
                begin
                    r = stk[sp-1];
                    stk[sp-1] = stk[sp-2];
                    stk[sp-2] = r;
                end
            OP_JMP:
                jmp = 1'b1;
            OP_JIF, OP_JNIF:
                if (sp < 1) st = ST_UNDER;
                else
                begin
                    sp--;
                    if ((stk[sp] != 0) == (op == OP_JIF)) jmp = 1'b1;
                end
            default: ;
        endcase
        sp_model = sp;
        o.top = (sp > 0) ? stk[sp-1] : '0;
        o.depth = 9'(sp);
        o.jmp = jmp;
        o.target = jmp ? imm[15:0] : '0;
        o.st = st;
        return o;
    endfunction

    task automatic add_instr(input logic [4:0] op, input logic [31:0] imm);
        instr_t t;
        t.op = op;
        t.imm = imm;
        instr_q.push_back(t);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 10)) - 32'd5;
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'($urandom_range(0, 3));
        endcase
    endfunction

    // driver: one instruction in flight, random idle bursts until the tail
    always @(negedge clk)
    begin
        logic nxt_start;
        instr_t t;
        // drop start once the monitor has seen the held transaction accepted
        nxt_start = start && (n_accepted != n_driven);
        if (rst_n && !nxt_start)
        begin
            if (gap > 0)
                gap--;
            else if (instr_q.size() > 0)
            begin
                if (instr_q.size() > 250 && $urandom_range(0, 7) == 0)
                    gap = int'($urandom_range(1, 18));
                else
                begin
                    t = instr_q.pop_front();
                    operation <= t.op;
                    immediate <= t.imm;
                    nxt_start = 1'b1;
                    n_driven++;
                end
            end
        end
        start <= nxt_start;
    end

    // monitor: check results first, then predict the transaction accepted at this edge
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n)
        begin
            if (done)
            begin
                n_checked++;
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result top=%0h depth=%0d", $time, top_value,
                             stack_depth);
                end
                else
                begin
                    e = outcome_q.pop_front();
                    if (top_value !== e.top)
                    begin
                        errors++;
                        $display("%0t: top_value expected %0h actual %0h", $time, e.top,
                                 top_value);
                    end
                    if (stack_depth !== e.depth)
                    begin
                        errors++;
                        $display("%0t: stack_depth expected %0d actual %0d", $time, e.depth,
                                 stack_depth);
                    end
                    if (jump_taken !== e.jmp)
                    begin
                        errors++;
                        $display("%0t: jump_taken expected %0b actual %0b", $time, e.jmp,
                                 jump_taken);
                    end
                    if (jump_target !== e.target)
                    begin
                        errors++;
                        $display("%0t: jump_target expected %0h actual %0h", $time, e.target,
                                 jump_target);
                    end
                    if (status !== e.st)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    end
                end
            end
            if (start && !busy)
            begin
                outcome_q.push_back(execute_instr(operation, immediate));
                n_accepted++;
            end
        end
    end

    initial
    begin
        int n, kind, cnt;
        logic [4:0] cop;
        rst_n = 1'b0;

        // directed: empty stack errors, extremes, wraps, division corners, count errors, rotate-n, jumps, unknown op
        add_instr(OP_POP, 0);
        add_instr(OP_ADD, 0);
        add_instr(OP_JIF, 32'h1234);
        add_instr(OP_JMP, 32'hffff_ffff);
        add_instr(OP_PUSH, 32'h7fff_ffff);
        add_instr(OP_INC, 0);
        add_instr(OP_PUSH, 32'hffff_ffff);
        add_instr(OP_DIV, 0);
        add_instr(OP_PUSH, 0);
        add_instr(OP_MOD, 0);
        add_instr(OP_PUSH, 32'h8000_0000);
        add_instr(OP_PUSH, 32'hffff_ffff);
        add_instr(OP_MOD, 0);
        add_instr(OP_PUSH, 32'h8000_0000);
        add_instr(OP_PUSH, 32'hffff_ffff);
        add_instr(OP_DIV, 0);
        add_instr(OP_PUSH, -32'sd7);
        add_instr(OP_PUSH, 32'd2);
        add_instr(OP_DIV, 0);
        add_instr(OP_DEPTH, 0);
        add_instr(OP_PUSH, 0);
        add_instr(OP_DUPN, 0);
        add_instr(OP_PUSH, -32'sd1);
        add_instr(OP_POPN, 0);
        add_instr(OP_PUSH, -32'sd2);
        add_instr(OP_ROTN, 0);
        add_instr(OP_PUSH, 0);
        add_instr(OP_ROTN, 0);
        add_instr(OP_JNIF, 32'hbeef);
        add_instr(5'd31, 32'hffff_ffff);

        while (instr_q.size() < 1750)
        begin
            kind = int'($urandom_range(0, 9));
            if (kind <= 3)
                add_instr(OP_PUSH, rand_value());
            else if (kind == 4)
            begin
                // counted operation with a small, mostly valid count
                cnt = int'($urandom_range(0, 8)) - 3;
                if ($urandom_range(0, 15) == 0) cnt = int'($urandom_range(200, 300));
                cop = ($urandom_range(0, 2) == 0) ? OP_DUPN :
                      ($urandom_range(0, 1) ? OP_POPN : OP_ROTN);
                add_instr(OP_PUSH, 32'(cnt));
                add_instr(cop, rand_value());
            end
            else if (kind == 5)
            begin
                n = int'($urandom_range(20, 70));
                repeat (n) add_instr(OP_PUSH, rand_value());
            end
            else if (kind == 6)
            begin
                n = int'($urandom_range(20, 70));
                repeat (n) add_instr(OP_POP, rand_value());
            end
            else
                add_instr(5'($urandom_range(0, 31)), rand_value());
        end
        n_items = instr_q.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (n_checked == n_items);
        repeat (20) @(posedge clk);
        if (errors == 0 && outcome_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/sme_pkg.sv
hw/rtl/sme_divider.sv
hw/rtl/stack_machine_execute.sv
test/stack_machine_execute_tb.sv
